// ===== sv/mpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// mpfr_pkg: shared types and constants for the page fault resolver
// Region entry layout, result layout, codes and sequencer states.
// ----------------------------------------------------------------------------
package mpfr_pkg;

  localparam int unsigned REGION_COUNT_DEF = 64;
  localparam logic [31:0] MAP_BASE_DEF     = 32'h4000_0000;
  localparam int unsigned PAGE_BYTES_DEF   = 4096;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned IDX_FIELD_W = 6;

  typedef logic [1:0] prot_t;

  localparam prot_t       PROT_RD_ONLY = 2'd1;
  localparam int unsigned PROT_WR_BIT  = 1;

  typedef enum logic [0:0] {
    ACT_LOAD  = 1'b0,
    ACT_FAULT = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_FOUND    = 2'd1,
    ST_WRITE_DENIED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
    prot_t             prot;
    logic              file_backed;
    logic [ADDR_W-1:0] file_off;
  } region_t;

  typedef struct packed {
    logic    valid;
    region_t entry;
  } rd_rsp_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] base;
    prot_t             prot;
    logic              file_backed;
    logic [ADDR_W-1:0] file_off;
  } match_t;

  typedef struct packed {
    status_t                status;
    logic [ADDR_W-1:0]      page_address;
    logic [IDX_FIELD_W-1:0] region_index;
    logic                   file_backed;
    logic [ADDR_W-1:0]      file_off;
    logic                   writable;
  } result_t;

endpackage

// ===== sv/mpfr_in_if.sv =====
// ----------------------------------------------------------------------------
// mpfr_in_if: request channel
// Table loads and fault requests with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpfr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [5:0]  entry_index;
  logic [31:0] region_start;
  logic [31:0] region_length;
  logic [1:0]  region_prot;
  logic        region_file_backed;
  logic [31:0] region_file_off;
  logic [31:0] fault_addr;
  logic        is_write;

  modport source (
    output valid, action, entry_index, region_start, region_length, region_prot,
           region_file_backed, region_file_off, fault_addr, is_write,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, region_start, region_length, region_prot,
           region_file_backed, region_file_off, fault_addr, is_write,
    output ready
  );
endinterface

// ===== sv/mpfr_out_if.sv =====
// ----------------------------------------------------------------------------
// mpfr_out_if: result channel
// Fault resolution results with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] page_address;
  logic [5:0]  region_index;
  logic        file_backed;
  logic [31:0] file_off;
  logic        writable;

  modport source (
    output valid, status, page_address, region_index, file_backed, file_off,
           writable,
    input  ready
  );

  modport sink (
    input  valid, status, page_address, region_index, file_backed, file_off,
           writable,
    output ready
  );
endinterface

// ===== sv/mpfr_table.sv =====
// ----------------------------------------------------------------------------
// mpfr_table: region table storage
// One write port, one registered read port; per-entry valid bits cleared
// by reset so an unwritten entry reads as all zeros.
// ----------------------------------------------------------------------------
module mpfr_table #(
  parameter int unsigned REGION_COUNT = mpfr_pkg::REGION_COUNT_DEF,
  parameter int unsigned IDX_W        = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  mpfr_pkg::region_t    wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output mpfr_pkg::rd_rsp_t    rd_rsp
);
  import mpfr_pkg::*;

  region_t                 mem [REGION_COUNT];
  logic [REGION_COUNT-1:0] vld_r;
  region_t                 rd_entry_r;
  logic                    rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_rsp.valid = rd_vld_r;
  assign rd_rsp.entry = rd_vld_r ? rd_entry_r : '0;

endmodule

// ===== sv/mpfr_match.sv =====
// ----------------------------------------------------------------------------
// mpfr_match: range compare unit
// Forms the region base and wrapped end, and tests the fault address.
// ----------------------------------------------------------------------------
module mpfr_match #(
  parameter logic [31:0] MAP_BASE = mpfr_pkg::MAP_BASE_DEF
) (
  input  logic [mpfr_pkg::ADDR_W-1:0] addr,
  input  mpfr_pkg::rd_rsp_t           rsp,
  output mpfr_pkg::match_t            result
);
  import mpfr_pkg::*;

  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] lim;

  assign base = MAP_BASE + rsp.entry.start;
  assign lim  = base + rsp.entry.length;

  assign result.hit         = rsp.valid && (addr >= base) && (addr < lim);
  assign result.base        = base;
  assign result.prot        = rsp.entry.prot;
  assign result.file_backed = rsp.entry.file_backed;
  assign result.file_off    = rsp.entry.file_off;

endmodule

// ===== sv/mpfr_seq.sv =====
// ----------------------------------------------------------------------------
// mpfr_seq: scan sequencer
// Walks the table one entry per cycle, keeps the last hit and builds the
// result into the output register.
// ----------------------------------------------------------------------------
module mpfr_seq #(
  parameter int unsigned REGION_COUNT = mpfr_pkg::REGION_COUNT_DEF,
  parameter int unsigned PAGE_BYTES   = mpfr_pkg::PAGE_BYTES_DEF,
  parameter int unsigned IDX_W        = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_action,
  input  logic [mpfr_pkg::ADDR_W-1:0] in_fault_addr,
  input  logic                        in_is_write,
  output logic                        in_ready,
  output logic                        rd_en,
  output logic [IDX_W-1:0]            rd_addr,
  output logic [mpfr_pkg::ADDR_W-1:0] addr,
  input  mpfr_pkg::match_t            match,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mpfr_pkg::result_t           out_data
);
  import mpfr_pkg::*;

  localparam int unsigned       CNT_W     = $clog2(REGION_COUNT + 1);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(REGION_COUNT - 1);
  localparam logic [ADDR_W-1:0] PAGE_MASK = ~(ADDR_W'(PAGE_BYTES - 1));

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [ADDR_W-1:0] addr_r;
  logic              wr_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              found_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [ADDR_W-1:0] hit_base_r;
  prot_t             hit_prot_r;
  logic              hit_fb_r;
  logic [ADDR_W-1:0] hit_foff_r;
  logic              out_valid_r;
  result_t           out_data_r;
  logic              finish;
  logic              fault_start;
  logic [ADDR_W-1:0] page;
  result_t           res;

  assign fault_start = in_valid && in_ready && (action_t'(in_action) == ACT_FAULT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (fault_start) state_nxt = S_SCAN;
      S_SCAN:   if (cnt_r == CNT_LAST) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_FINISH;
      S_FINISH: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    finish   = 1'b0;
    unique case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_SCAN:   rd_en    = 1'b1;
      S_DRAIN:  ;
      S_FINISH: finish   = !out_valid_r || out_ready;
    endcase
  end

  assign rd_addr = cnt_r[IDX_W-1:0];
  assign addr    = addr_r;
  assign page    = addr_r & PAGE_MASK;

  always_comb begin
    res              = '0;
    res.status       = ST_NOT_FOUND;
    res.page_address = page;
    if (found_r) begin
      res.region_index = IDX_FIELD_W'(hit_idx_r);
      if (hit_prot_r == PROT_RD_ONLY && wr_r) begin
        res.status = ST_WRITE_DENIED;
      end else begin
        res.status   = ST_OK;
        res.writable = hit_prot_r[PROT_WR_BIT];
        if (hit_fb_r) begin
          res.file_backed = 1'b1;
          res.file_off    = hit_foff_r + (page - hit_base_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= rd_en;
      if (fault_start) begin
        cnt_r   <= '0;
        found_r <= 1'b0;
      end else if (rd_en) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmp_vld_r && match.hit) begin
        found_r <= 1'b1;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fault_start) begin
      addr_r <= in_fault_addr;
      wr_r   <= in_is_write;
    end
    cmp_idx_r <= rd_addr;
    if (cmp_vld_r && match.hit) begin
      hit_idx_r  <= cmp_idx_r;
      hit_base_r <= match.base;
      hit_prot_r <= match.prot;
      hit_fb_r   <= match.file_backed;
      hit_foff_r <= match.file_off;
    end
    if (finish) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/mmap_page_fault_resolver.sv =====
// ----------------------------------------------------------------------------
// mmap_page_fault_resolver: region lookup for demand-paged memory maps
// Load: written to the table on the transfer, no result. Fault: the table
// is scanned at one entry per read-port cycle; ready again once the result
// is registered. Reset clears all entry valid bits at once, no sweep.
// ----------------------------------------------------------------------------
module mmap_page_fault_resolver #(
  parameter int unsigned REGION_COUNT = mpfr_pkg::REGION_COUNT_DEF,
  parameter logic [31:0] MAP_BASE     = mpfr_pkg::MAP_BASE_DEF,
  parameter int unsigned PAGE_BYTES   = mpfr_pkg::PAGE_BYTES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  mpfr_in_if.sink   in_ch,
  mpfr_out_if.source out_ch
);
  import mpfr_pkg::*;

  localparam int unsigned IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  region_t           wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  rd_rsp_t           rd_rsp;
  match_t            match;
  logic [ADDR_W-1:0] scan_addr;
  result_t           out_data;

  assign wr_en = in_ch.valid && in_ch.ready && (action_t'(in_ch.action) == ACT_LOAD) &&
                 (32'(in_ch.entry_index) < REGION_COUNT);
  assign wr_idx              = IDX_W'(in_ch.entry_index);
  assign wr_data.start       = in_ch.region_start;
  assign wr_data.length      = in_ch.region_length;
  assign wr_data.prot        = in_ch.region_prot;
  assign wr_data.file_backed = in_ch.region_file_backed;
  assign wr_data.file_off    = in_ch.region_file_off;

  mpfr_table #(
    .REGION_COUNT(REGION_COUNT),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_rsp (rd_rsp)
  );

  mpfr_match #(
    .MAP_BASE(MAP_BASE)
  ) u_match (
    .addr  (scan_addr),
    .rsp   (rd_rsp),
    .result(match)
  );

  mpfr_seq #(
    .REGION_COUNT(REGION_COUNT),
    .PAGE_BYTES  (PAGE_BYTES),
    .IDX_W       (IDX_W)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_action    (in_ch.action),
    .in_fault_addr(in_ch.fault_addr),
    .in_is_write  (in_ch.is_write),
    .in_ready     (in_ch.ready),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .addr         (scan_addr),
    .match        (match),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_data     (out_data)
  );

  assign out_ch.status       = out_data.status;
  assign out_ch.page_address = out_data.page_address;
  assign out_ch.region_index = out_data.region_index;
  assign out_ch.file_backed  = out_data.file_backed;
  assign out_ch.file_off     = out_data.file_off;
  assign out_ch.writable     = out_data.writable;

`ifndef SYNTH
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !rd_en)
    else $error("table write during scan");

  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> !in_ch.ready)
    else $error("request taken while scan still running");

  a_fault_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (action_t'(in_ch.action) == ACT_FAULT)) |=> rd_en)
    else $error("fault transfer did not start a scan");

  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (status_t'(out_ch.status) == ST_NOT_FOUND)) |->
    (out_ch.region_index == '0 && !out_ch.writable && !out_ch.file_backed))
    else $error("miss result carries region data");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: page fault resolver bench
// Table loads and fault lookups go out from a queue of pending requests. A
// predictor keeps its own copy of the region table and works out each fault
// result. The monitor checks the results in order, field by field. Directed
// corner cases run first, then random traffic in phases of sender idling and
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import mpfr_pkg::*;

  localparam int unsigned SCAN_LATENCY   = REGION_COUNT_DEF + 2;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 320;
  localparam int unsigned PRINT_CAP      = 100;

  typedef struct packed {
    action_t     action;
    logic [5:0]  entry_index;
    logic [31:0] region_start;
    logic [31:0] region_length;
    prot_t       region_prot;
    logic        region_file_backed;
    logic [31:0] region_file_off;
    logic [31:0] fault_addr;
    logic        is_write;
    logic        wait_drain;
  } request_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  mpfr_in_if  in_ch ();
  mpfr_out_if out_ch ();

  mmap_page_fault_resolver u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  request_t    request_q[$];
  request_t    cur_req = '0;
  bit          have_req = 1'b0;
  result_t     fault_expect[$];
  region_t     region_tbl [REGION_COUNT_DEF];
  logic [31:0] plan_start [REGION_COUNT_DEF];
  logic [31:0] plan_len   [REGION_COUNT_DEF];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    // keep the log short on a badly broken design
    if (mismatch_count <= PRINT_CAP)
      $display("%0t: %s got %h expected %h", $time, what, got, want);
  endtask

  function automatic result_t resolve_fault(input logic [31:0] addr, input logic wr);
    result_t     res;
    logic [31:0] base;
    logic [31:0] lim;
    logic [31:0] hit_base;
    logic        hit;
    int          hit_idx;
    int          i;
    hit      = 1'b0;
    hit_idx  = 0;
    hit_base = '0;
    for (i = 0; i < REGION_COUNT_DEF; i++) begin
      base = MAP_BASE_DEF + region_tbl[i].start;
      lim  = base + region_tbl[i].length;
      if (addr >= base && addr < lim) begin
        hit      = 1'b1;
        hit_idx  = i;
        hit_base = base;
      end
    end
    res              = '0;
    res.status       = ST_NOT_FOUND;
    res.page_address = addr - (addr % PAGE_BYTES_DEF);
    if (hit) begin
      res.region_index = 6'(hit_idx);
      if (region_tbl[hit_idx].prot == PROT_RD_ONLY && wr) begin
        res.status = ST_WRITE_DENIED;
      end else begin
        res.status   = ST_OK;
        res.writable = region_tbl[hit_idx].prot[PROT_WR_BIT];
        if (region_tbl[hit_idx].file_backed) begin
          res.file_backed = 1'b1;
          res.file_off    = region_tbl[hit_idx].file_off + (res.page_address - hit_base);
        end
      end
    end
    return res;
  endfunction

  task automatic queue_load(input logic [5:0] idx, input logic [31:0] start,
                            input logic [31:0] len, input prot_t prot,
                            input logic fb, input logic [31:0] foff);
    request_t r;
    r.action             = ACT_LOAD;
    r.entry_index        = idx;
    r.region_start       = start;
    r.region_length      = len;
    r.region_prot        = prot;
    r.region_file_backed = fb;
    r.region_file_off    = foff;
    r.fault_addr         = $urandom;
    r.is_write           = 1'($urandom_range(1));
    r.wait_drain         = 1'b0;
    plan_start[idx]      = start;
    plan_len[idx]        = len;
    request_q.push_back(r);
  endtask

  task automatic queue_fault(input logic [31:0] addr, input logic wr);
    request_t r;
    r.action             = ACT_FAULT;
    r.entry_index        = 6'($urandom_range(63));
    r.region_start       = $urandom;
    r.region_length      = $urandom;
    r.region_prot        = 2'($urandom_range(3));
    r.region_file_backed = 1'($urandom_range(1));
    r.region_file_off    = $urandom;
    r.fault_addr         = addr;
    r.is_write           = wr;
    r.wait_drain         = 1'b0;
    request_q.push_back(r);
  endtask

  // driver: holds valid until the transfer, updates the predictor on it
  always @(posedge clk) begin
    logic accepted;
    logic next_valid;
    if (!rst_n) begin
      in_ch.valid              <= 1'b0;
      in_ch.action             <= ACT_LOAD;
      in_ch.entry_index        <= '0;
      in_ch.region_start       <= '0;
      in_ch.region_length      <= '0;
      in_ch.region_prot        <= '0;
      in_ch.region_file_backed <= 1'b0;
      in_ch.region_file_off    <= '0;
      in_ch.fault_addr         <= '0;
      in_ch.is_write           <= 1'b0;
      foreach (region_tbl[i]) region_tbl[i] = '0;
    end else begin
      accepted = in_ch.valid && in_ch.ready;
      if (accepted) begin
        if (cur_req.action == ACT_LOAD) begin
          region_tbl[cur_req.entry_index].start       = cur_req.region_start;
          region_tbl[cur_req.entry_index].length      = cur_req.region_length;
          region_tbl[cur_req.entry_index].prot        = cur_req.region_prot;
          region_tbl[cur_req.entry_index].file_backed = cur_req.region_file_backed;
          region_tbl[cur_req.entry_index].file_off    = cur_req.region_file_off;
        end else begin
          fault_expect.push_back(resolve_fault(cur_req.fault_addr, cur_req.is_write));
        end
        have_req = 1'b0;
      end
      if (!have_req && request_q.size() != 0 &&
          (!request_q[0].wait_drain || fault_expect.size() == 0)) begin
        cur_req  = request_q.pop_front();
        have_req = 1'b1;
      end
      if (!have_req)
        next_valid = 1'b0;
      else if (in_ch.valid && !accepted)
        next_valid = 1'b1;
      else
        next_valid = ($urandom_range(99) >= send_idle_pct);
      in_ch.valid              <= next_valid;
      in_ch.action             <= cur_req.action;
      in_ch.entry_index        <= cur_req.entry_index;
      in_ch.region_start       <= cur_req.region_start;
      in_ch.region_length      <= cur_req.region_length;
      in_ch.region_prot        <= cur_req.region_prot;
      in_ch.region_file_backed <= cur_req.region_file_backed;
      in_ch.region_file_off    <= cur_req.region_file_off;
      in_ch.fault_addr         <= cur_req.fault_addr;
      in_ch.is_write           <= cur_req.is_write;
    end
  end

  // monitor: random backpressure, in-order compare
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (fault_expect.size() == 0) begin
          report_mismatch("unexpected result, page_address", out_ch.page_address, '0);
        end else begin
          want = fault_expect.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", 32'(out_ch.status), 32'(want.status));
          if (out_ch.page_address !== want.page_address)
            report_mismatch("page_address", out_ch.page_address, want.page_address);
          if (out_ch.region_index !== want.region_index)
            report_mismatch("region_index", 32'(out_ch.region_index), 32'(want.region_index));
          if (out_ch.file_backed !== want.file_backed)
            report_mismatch("file_backed", 32'(out_ch.file_backed), 32'(want.file_backed));
          if (out_ch.file_off !== want.file_off)
            report_mismatch("file_off", out_ch.file_off, want.file_off);
          if (out_ch.writable !== want.writable)
            report_mismatch("writable", 32'(out_ch.writable), 32'(want.writable));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int          ph;
    int          n;
    int unsigned r;
    logic [5:0]  idx;
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] base;
    logic [31:0] addr;

    foreach (plan_start[i]) begin
      plan_start[i] = '0;
      plan_len[i]   = '0;
    end

    // empty table, address extremes
    queue_fault(32'h0000_0000, 1'b0);
    queue_fault(32'hFFFF_FFFF, 1'b1);
    // read-only file region: denied write, read hit, exclusive end, below base
    queue_load(6'd0, 32'h0000_0000, 32'h0000_3000, PROT_RD_ONLY, 1'b1, 32'h0000_1000);
    request_q[$].wait_drain = 1'b1;
    queue_fault(MAP_BASE_DEF + 32'h10, 1'b1);
    queue_fault(MAP_BASE_DEF + 32'h2FFF, 1'b0);
    queue_fault(MAP_BASE_DEF + 32'h3000, 1'b0);
    queue_fault(MAP_BASE_DEF - 32'h1, 1'b0);
    // unaligned overlapping entry, later index wins, page below region base
    queue_load(6'd63, 32'h0000_1800, 32'h0000_1000, 2'd2, 1'b1, 32'hFFFF_F000);
    queue_fault(MAP_BASE_DEF + 32'h1800, 1'b0);
    queue_fault(MAP_BASE_DEF + 32'h2000, 1'b1);
    // no-permission anonymous region with a write
    queue_load(6'd5, 32'h0001_0000, 32'h0000_1000, 2'd0, 1'b0, 32'h1234_5678);
    queue_fault(MAP_BASE_DEF + 32'h0001_0ABC, 1'b1);
    // one-byte read/write region
    queue_load(6'd6, 32'h0002_0000, 32'h0000_0001, 2'd3, 1'b0, 32'h0);
    queue_fault(MAP_BASE_DEF + 32'h0002_0000, 1'b1);
    // range end wraps past 2^32
    queue_load(6'd7, 32'hBFFF_F000, 32'h0000_2000, 2'd3, 1'b1, 32'h0);
    queue_fault(32'hFFFF_F800, 1'b0);
    // base itself wraps to zero
    queue_load(6'd8, 32'hC000_0000, 32'h0000_1000, 2'd3, 1'b1, 32'hABC0_0000);
    queue_fault(32'h0000_0123, 1'b1);
    // clear an entry by zero length
    queue_load(6'd0, 32'h0, 32'h0, 2'd0, 1'b0, 32'h0);
    queue_fault(MAP_BASE_DEF + 32'h10, 1'b0);
    // all-ones load fields
    queue_load(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1'b1, 32'hFFFF_FFFF);
    queue_fault(32'h3FFF_FFFF, 1'b1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (request_q.size() != 0) @(posedge clk);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r   = $urandom_range(99);
        idx = 6'($urandom_range(63));
        if (r < 30) begin
          r = $urandom_range(99);
          if (r < 10) begin
            start = $urandom;
            len   = $urandom;
          end else begin
            start = $urandom_range(32'h0004_0000);
            if ($urandom_range(1)) start[11:0] = '0;
            len = (r < 16) ? 32'h0 : $urandom_range(32'h0000_8000, 1);
          end
          queue_load(idx, start, len, 2'($urandom_range(3)), 1'($urandom_range(1)), $urandom);
        end else begin
          r    = $urandom_range(99);
          base = MAP_BASE_DEF + plan_start[idx];
          if (r < 55 && plan_len[idx] != 0) begin
            addr = base + ($urandom % plan_len[idx]);
          end else if (r < 70) begin
            case ($urandom_range(3))
              0: addr = base - 32'h1;
              1: addr = base;
              2: addr = base + plan_len[idx] - 32'h1;
              default: addr = base + plan_len[idx];
            endcase
          end else if (r < 85) begin
            addr = MAP_BASE_DEF + $urandom_range(32'h0005_0000);
          end else begin
            addr = $urandom;
          end
          queue_fault(addr, 1'($urandom_range(1)));
        end
        if (n == 0) request_q[$].wait_drain = 1'b1;
      end
      while (request_q.size() != 0) @(posedge clk);
    end

    while (have_req) @(posedge clk);
    while (fault_expect.size() != 0) @(posedge clk);
    repeat (2 * SCAN_LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mpfr_pkg.sv
sv/mpfr_in_if.sv
sv/mpfr_out_if.sv
sv/mpfr_table.sv
sv/mpfr_match.sv
sv/mpfr_seq.sv
sv/mmap_page_fault_resolver.sv
bench/testbench.sv
